// File: rtl/core/msd_pkg.sv
// shared constants, result type and symbol table of the morse stream decoder
package msd_pkg;

   // field and state widths
   localparam int CHAR_W = 8;
   localparam int PAT_W  = 6;
   localparam int LEN_W  = 3;
   localparam int GAP_W  = 3;

   // command codes of the input channel
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_EOM  = 1'b1;

   // result kinds
   localparam logic KIND_TEXT   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // characters of the message alphabet
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

   // token and gap limits
   localparam logic [LEN_W-1:0] TOKEN_MAX    = 3'd6;
   localparam logic [LEN_W-1:0] OVERFLOW_LEN = 3'd7;
   localparam logic [GAP_W-1:0] WORD_GAP     = 3'd3;
   localparam logic [GAP_W-1:0] GAP_SAT      = 3'd4;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] text_char;
      logic              error;
      logic              last;
   } rsp_type;

   // symbol table: dot is 0, dash is 1, first symbol in the highest used bit
   function automatic logic [CHAR_W-1:0] rom_lookup(input logic [LEN_W-1:0] len,
                                                    input logic [PAT_W-1:0] pat);
      logic [CHAR_W-1:0] ch;
      ch = CHAR_NONE;
      case ({len, pat})
         {3'd1, 6'b000000}: ch = "e";
         {3'd1, 6'b000001}: ch = "t";
         {3'd2, 6'b000001}: ch = "a";
         {3'd2, 6'b000000}: ch = "i";
         {3'd2, 6'b000011}: ch = "m";
         {3'd2, 6'b000010}: ch = "n";
         {3'd3, 6'b000100}: ch = "d";
         {3'd3, 6'b000110}: ch = "g";
         {3'd3, 6'b000101}: ch = "k";
         {3'd3, 6'b000111}: ch = "o";
         {3'd3, 6'b000010}: ch = "r";
         {3'd3, 6'b000000}: ch = "s";
         {3'd3, 6'b000001}: ch = "u";
         {3'd3, 6'b000011}: ch = "w";
         {3'd4, 6'b001000}: ch = "b";
         {3'd4, 6'b001010}: ch = "c";
         {3'd4, 6'b000010}: ch = "f";
         {3'd4, 6'b000000}: ch = "h";
         {3'd4, 6'b000111}: ch = "j";
         {3'd4, 6'b000100}: ch = "l";
         {3'd4, 6'b000110}: ch = "p";
         {3'd4, 6'b001101}: ch = "q";
         {3'd4, 6'b000001}: ch = "v";
         {3'd4, 6'b001001}: ch = "x";
         {3'd4, 6'b001011}: ch = "y";
         {3'd4, 6'b001100}: ch = "z";
         {3'd5, 6'b011111}: ch = "0";
         {3'd5, 6'b001111}: ch = "1";
         {3'd5, 6'b000111}: ch = "2";
         {3'd5, 6'b000011}: ch = "3";
         {3'd5, 6'b000001}: ch = "4";
         {3'd5, 6'b000000}: ch = "5";
         {3'd5, 6'b010000}: ch = "6";
         {3'd5, 6'b011000}: ch = "7";
         {3'd5, 6'b011100}: ch = "8";
         {3'd5, 6'b011110}: ch = "9";
         {3'd5, 6'b010010}: ch = "/";
         {3'd5, 6'b001010}: ch = "+";
         {3'd5, 6'b010001}: ch = "=";
         {3'd6, 6'b001100}: ch = "?";
         {3'd6, 6'b110011}: ch = ",";
         {3'd6, 6'b010101}: ch = ".";
         default:           ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/core/msd_req_if.sv
// input channel of the morse stream decoder
interface msd_req_if;
   import msd_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CHAR_W-1:0] symbol_char;

   modport source (output valid, cmd, symbol_char, input ready);
   modport sink   (input valid, cmd, symbol_char, output ready);
endinterface

// File: rtl/core/msd_rsp_if.sv
// result channel of the morse stream decoder
interface msd_rsp_if;
   import msd_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAR_W-1:0] text_char;
   logic              error;
   logic              last;

   modport source (output valid, kind, text_char, error, last, input ready);
   modport sink   (input valid, kind, text_char, error, last, output ready);
endinterface

// File: rtl/core/morse_stream_decoder.sv
// morse stream decoder: morse text characters in, decoded ascii and status out
// flow: a transaction is registered, then decoded; its results are written to the result queue
// throughput: one input transaction per cycle while two queue entries are free, set by the single
//    decode stage and a four-entry result queue (up to two results per end-of-message transaction)
// reset: synchronous, clears token, gap and error state and empties the queue;
//    the block takes a transaction in the first cycle after reset
module morse_stream_decoder (
   input logic        clock,
   input logic        reset,
   msd_req_if.sink    req_chan,
   msd_rsp_if.source  rsp_chan
);
   import msd_pkg::*;

   // input register
   logic              s0_valid_ff, s0_valid_in;
   logic              s0_cmd_ff;
   logic [CHAR_W-1:0] s0_char_ff;
   logic              req_take;
   logic              s0_fire;

   // decoder state
   logic [PAT_W-1:0]  pat_ff, pat_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic              inv_ff, inv_in;
   logic              failed_ff, failed_in;

   // result queue
   rsp_type           fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pop;

   // decode signals
   logic              is_dot, is_dash, is_space;
   logic [CHAR_W-1:0] rom_char, tok_char;
   logic              tok_open, fail_tok, emit_char, emit_ws, text_valid;
   logic [GAP_W-1:0]  gap_inc;
   logic [1:0]        push_n;
   rsp_type           res0, res1;

   // input register takes a transaction when empty or when its item moves on
   assign s0_fire        = s0_valid_ff && (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_chan.ready = !s0_valid_ff || s0_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_take) begin
         s0_valid_in = 1'b1;
      end else if (s0_fire) begin
         s0_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      if (req_take) begin
         s0_cmd_ff  <= req_chan.cmd;
         s0_char_ff <= req_chan.symbol_char;
      end
   end

   // decode of one item against the token state
   always_comb begin
      is_dot    = (s0_char_ff == CHAR_DOT);
      is_dash   = (s0_char_ff == CHAR_DASH);
      is_space  = (s0_char_ff == CHAR_SPACE);
      rom_char  = rom_lookup(len_ff, pat_ff);
      tok_open  = (len_ff != '0);
      tok_char  = (!inv_ff && (len_ff <= TOKEN_MAX)) ? rom_char : CHAR_NONE;
      gap_inc   = (gap_ff < GAP_SAT) ? gap_ff + GAP_W'(1) : gap_ff;
      fail_tok  = failed_ff || (tok_open && (tok_char == CHAR_NONE));
      emit_char = tok_open && (tok_char != CHAR_NONE) && !failed_ff;
      emit_ws   = (gap_inc == WORD_GAP) && !fail_tok;
      text_valid = emit_char || emit_ws;

      pat_in    = pat_ff;
      len_in    = len_ff;
      gap_in    = gap_ff;
      inv_in    = inv_ff;
      failed_in = failed_ff;
      push_n    = 2'd0;
      res0      = '0;
      res1      = '0;

      if ((s0_cmd_ff == CMD_CHAR) && !is_space) begin
         // symbol joins the open token
         if (len_ff < TOKEN_MAX) begin
            if (is_dot || is_dash) begin
               pat_in = {pat_ff[PAT_W-2:0], is_dash};
            end
            len_in = len_ff + LEN_W'(1);
         end else begin
            len_in = OVERFLOW_LEN;
         end
         if (!(is_dot || is_dash)) begin
            inv_in = 1'b1;
         end
         gap_in = '0;
      end else begin
         // space, or end of message acting as one
         if (tok_open) begin
            pat_in = '0;
            len_in = '0;
            inv_in = 1'b0;
         end
         gap_in    = gap_inc;
         failed_in = fail_tok;

         res0.kind      = KIND_TEXT;
         res0.text_char = emit_char ? tok_char : CHAR_SPACE;
         res0.error     = 1'b0;
         res0.last      = (s0_cmd_ff == CMD_CHAR);

         res1.kind      = KIND_STATUS;
         res1.text_char = CHAR_NONE;
         res1.error     = fail_tok;
         res1.last      = 1'b1;

         if (s0_cmd_ff == CMD_EOM) begin
            if (text_valid) begin
               push_n = 2'd2;
            end else begin
               push_n = 2'd1;
               res0   = res1;
            end
            pat_in    = '0;
            len_in    = '0;
            gap_in    = '0;
            inv_in    = 1'b0;
            failed_in = 1'b0;
         end else if (text_valid) begin
            push_n = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff    <= '0;
         len_ff    <= '0;
         gap_ff    <= '0;
         inv_ff    <= 1'b0;
         failed_ff <= 1'b0;
      end else if (s0_fire) begin
         pat_ff    <= pat_in;
         len_ff    <= len_in;
         gap_ff    <= gap_in;
         inv_ff    <= inv_in;
         failed_ff <= failed_in;
      end
   end

   // result queue pointers and fill count
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff - CNT_W'(pop);
      if (s0_fire) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
         cnt_in    = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);
      end
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (s0_fire && (push_n != 2'd0)) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (s0_fire && (push_n == 2'd2)) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   // head of the queue drives the result channel
   assign rsp_chan.valid     = (cnt_ff != '0);
   assign rsp_chan.kind      = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.text_char = fifo_ff[rd_ptr_ff].text_char;
   assign rsp_chan.error     = fifo_ff[rd_ptr_ff].error;
   assign rsp_chan.last      = fifo_ff[rd_ptr_ff].last;

   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   // an open token means no space has followed the last symbol
   a_token_gap: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (gap_ff == '0))
      else $error("open token with non-zero gap count");

   // end of message leaves the decoder in its reset state
   a_eom_clear: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && (s0_cmd_ff == CMD_EOM)) |=>
         ((len_ff == '0) && (gap_ff == '0) && !failed_ff && !inv_ff))
      else $error("state not cleared after end of message");

   // gap count saturates
   a_gap_sat: assert property (@(posedge clock) disable iff (reset)
      gap_ff <= GAP_SAT)
      else $error("gap count past saturation");

endmodule
